[hw/rtl/cts_pkg.sv]
// ----------------------------------------------------------------------------
// Closure triangle selector package
// Shared widths, constants and the request record passed from front to back.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int MaxStations = 12;
  localparam int IdxW        = $clog2(MaxStations);
  localparam int CntW        = $clog2(MaxStations + 1);
  localparam int BaseDepth   = MaxStations * (MaxStations + 1) / 2;
  localparam int BaseW       = $clog2(BaseDepth + 1);
  localparam int TriDepth    = 55;
  localparam int TriW        = $clog2(TriDepth + 1);

  typedef enum logic [1:0] {
    StTriangle = 2'd0,
    StTooFew   = 2'd1,
    StTooMany  = 2'd2,
    StMismatch = 2'd3
  } status_e;

  // One request from the front to the back: a station code and a list-end flag.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } req_t;

endpackage

[hw/rtl/closure_triangle_selector_core.sv]
// ----------------------------------------------------------------------------
// Closure triangle selector
// Collects station lists and returns the closure triangle set per list.
// ----------------------------------------------------------------------------
// Channel   Handshake      Fields
// input     push / full    station_code, last_station
// result    pop / empty    vertex_a..c, triangle_count, status, last
//
// Stations are taken one per cycle, when not full, into a two-entry queue.
// On a valid list end the back end walks the triples in order, its
// baseline search scanning the store serially for each triple; a kept
// triple appends its missing baselines. Input stalls during the walk.
// Kept triangles leave one by one, held until popped. Reset clears all control
// state; the baseline store needs no clearing pass as a fill count bounds it.
// ----------------------------------------------------------------------------
module closure_triangle_selector_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] station_code_i,
  input  logic       last_station_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] vertex_a_o,
  output logic [7:0] vertex_b_o,
  output logic [7:0] vertex_c_o,
  output logic [5:0] triangle_count_o,
  output logic [1:0] status_o,
  output logic       last_o
);
  import cts_pkg::*;

  req_t in_req, q_req;
  logic q_valid, q_take;

  assign in_req.code = station_code_i;
  assign in_req.last = last_station_i;

  cts_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .req_i(in_req),
    .valid_o(q_valid), .take_i(q_take), .req_o(q_req)
  );

  cts_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .take_o(q_take), .req_i(q_req),
    .empty_o(empty), .pop_i(pop), .vertex_a_o, .vertex_b_o, .vertex_c_o,
    .triangle_count_o, .status_o, .last_o
  );
endmodule

[hw/rtl/cts_front.sv]
// ----------------------------------------------------------------------------
// Closure triangle selector front end
// Accepts station requests into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module cts_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  cts_pkg::req_t req_i,
  output logic          valid_o,
  input  logic          take_i,
  output cts_pkg::req_t req_o
);
  import cts_pkg::*;

  req_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign req_o   = mem_q[rd_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = take_i && valid_o;

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= req_i;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wr_q <= ~wr_q;
      if (rd_en) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule

[hw/rtl/cts_back.sv]
// ----------------------------------------------------------------------------
// Closure triangle selector back end
// Stores stations, walks triples, keeps triangles, and plays out results.
// ----------------------------------------------------------------------------
module cts_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               take_o,
  input  cts_pkg::req_t      req_i,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [7:0]         vertex_a_o,
  output logic [7:0]         vertex_b_o,
  output logic [7:0]         vertex_c_o,
  output logic [5:0]         triangle_count_o,
  output logic [1:0]         status_o,
  output logic               last_o
);
  import cts_pkg::*;

  typedef enum logic [6:0] {
    SLoad  = 7'b0000001,
    STri   = 7'b0000010,
    SScan  = 7'b0000100,
    SDec   = 7'b0001000,
    SApp   = 7'b0010000,
    SEmit  = 7'b0100000,
    SErr   = 7'b1000000
  } state_e;

  state_e            state_q;
  logic [7:0]        stn_q [MaxStations];
  logic [CntW-1:0]   n_q;
  logic              ovf_q;
  logic [15:0]       base_q [BaseDepth];
  logic [BaseW-1:0]  bcnt_q, prior_q, scan_q;
  logic [IdxW-1:0]   i_q, j_q, k_q;
  logic [7:0]        a_q, b_q, c_q;
  logic [15:0]       k1_q, k2_q, k3_q;
  logic              f1_q, f2_q, f3_q;
  logic [15:0]       ent_q;
  logic              chk_q;
  logic [2:0]        add_q;
  logic [23:0]       tri_q [TriDepth];
  logic [TriW-1:0]   kept_q, rd_q;
  logic [TriW-1:0]   exp_q;
  logic [23:0]       tri_rd_q;
  logic [1:0]        st_q;
  logic              outv_q;

  logic [15:0] key_ab, key_bc, key_ca, app_key;
  logic        wr_ok, n1, n2, n3, is_new;
  logic [2:0]  add_d, add_rest;
  logic [IdxW-1:0] ni, nj, nk;
  logic        has_next;

  function automatic logic [15:0] pkey(input logic [7:0] x, input logic [7:0] y);
    return (x < y) ? {x, y} : {y, x};
  endfunction

  assign key_ab = pkey(stn_q[i_q], stn_q[j_q]);
  assign key_bc = pkey(stn_q[j_q], stn_q[k_q]);
  assign key_ca = pkey(stn_q[k_q], stn_q[i_q]);
  assign n1     = !f1_q;
  assign n2     = !f2_q;
  assign n3     = !f3_q;
  assign is_new = n1 || n2 || n3;

  // Missing baselines of the triple, each distinct key appended once.
  assign add_d[0] = n1;
  assign add_d[1] = n2 && !(n1 && (k2_q == k1_q));
  assign add_d[2] = n3 && !(n1 && (k3_q == k1_q)) && !(n2 && (k3_q == k2_q));
  assign add_rest = add_q & (add_q - 3'd1);
  assign app_key  = add_q[0] ? k1_q : (add_q[1] ? k2_q : k3_q);

  // Next triple in lexicographic order.
  always_comb begin
    ni = i_q; nj = j_q; nk = k_q; has_next = 1'b1;
    if (CntW'(k_q) + 1'b1 < n_q) begin
      nk = k_q + 1'b1;
    end else if (CntW'(j_q) + 2'd2 < n_q) begin
      nj = j_q + 1'b1; nk = j_q + 2'd2;
    end else if (CntW'(i_q) + 2'd3 < n_q) begin
      ni = i_q + 1'b1; nj = i_q + 2'd2; nk = i_q + 2'd3;
    end else begin
      has_next = 1'b0;
    end
  end

  assign wr_ok   = (state_q == SLoad) && valid_i;
  assign take_o  = wr_ok;
  assign empty_o = !outv_q;

  // Result ports.
  assign vertex_a_o       = (st_q == StTriangle) ? tri_rd_q[23:16] : 8'd0;
  assign vertex_b_o       = (st_q == StTriangle) ? tri_rd_q[15:8]  : 8'd0;
  assign vertex_c_o       = (st_q == StTriangle) ? tri_rd_q[7:0]   : 8'd0;
  assign triangle_count_o = (st_q == StTriangle) ? kept_q : 6'd0;
  assign status_o         = st_q;
  assign last_o           = (st_q != StTriangle) || (rd_q + 1'b1 == kept_q);

  // Station, baseline and triangle storage, with registered baseline and triangle reads.
  always_ff @(posedge clk_i) begin
    if (wr_ok && n_q < CntW'(MaxStations)) begin
      stn_q[n_q[IdxW-1:0]] <= req_i.code;
    end
    if (state_q == SDec && is_new && kept_q < exp_q) begin
      tri_q[kept_q] <= {a_q, b_q, c_q};
    end
    // One missing baseline is appended per cycle.
    if (state_q == SApp && bcnt_q < BaseW'(BaseDepth)) begin
      base_q[bcnt_q] <= app_key;
    end
    ent_q    <= base_q[(scan_q < BaseW'(BaseDepth)) ? scan_q : '0];
    tri_rd_q <= tri_q[rd_q];
  end

  // Control sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad;
      n_q <= '0; ovf_q <= 1'b0; bcnt_q <= '0; kept_q <= '0;
      rd_q <= '0; st_q <= StTriangle; outv_q <= 1'b0;
      i_q <= '0; j_q <= '0; k_q <= '0; prior_q <= '0; scan_q <= '0;
      a_q <= '0; b_q <= '0; c_q <= '0; k1_q <= '0; k2_q <= '0; k3_q <= '0;
      f1_q <= 1'b0; f2_q <= 1'b0; f3_q <= 1'b0; exp_q <= '0;
      chk_q <= 1'b0; add_q <= '0;
    end else begin
      case (state_q)
        SLoad: begin
          if (wr_ok) begin
            if (n_q < CntW'(MaxStations)) n_q <= n_q + 1'b1;
            else ovf_q <= 1'b1;
            if (req_i.last) begin
              bcnt_q <= '0; kept_q <= '0; rd_q <= '0;
              if (ovf_q || n_q >= CntW'(MaxStations)) begin
                st_q <= StTooMany; state_q <= SErr; outv_q <= 1'b1;
              end else if (n_q < CntW'(2)) begin
                st_q <= StTooFew; state_q <= SErr; outv_q <= 1'b1;
              end else begin
                exp_q <= TriW'((8'(n_q) * (8'(n_q) - 8'd1)) >> 1);
                i_q <= '0; j_q <= IdxW'(1); k_q <= IdxW'(2);
                state_q <= STri;
              end
            end
          end
        end
        STri: begin
          a_q <= stn_q[i_q]; b_q <= stn_q[j_q]; c_q <= stn_q[k_q];
          k1_q <= key_ab; k2_q <= key_bc; k3_q <= key_ca;
          state_q <= SScan; scan_q <= '0; prior_q <= bcnt_q; chk_q <= 1'b0;
          f1_q <= 1'b0; f2_q <= 1'b0; f3_q <= 1'b0;
        end
        SScan: begin
          // The entry read in the previous cycle is compared now.
          if (chk_q) begin
            if (ent_q == k1_q) f1_q <= 1'b1;
            if (ent_q == k2_q) f2_q <= 1'b1;
            if (ent_q == k3_q) f3_q <= 1'b1;
          end
          if (scan_q < prior_q) begin
            scan_q <= scan_q + 1'b1; chk_q <= 1'b1;
          end else begin
            chk_q <= 1'b0; state_q <= SDec;
          end
        end
        SDec: begin
          if (is_new && kept_q >= exp_q) begin
            st_q <= StMismatch; state_q <= SErr; outv_q <= 1'b1;
          end else if (is_new) begin
            kept_q <= kept_q + 1'b1; add_q <= add_d; state_q <= SApp;
          end else if (has_next) begin
            i_q <= ni; j_q <= nj; k_q <= nk; state_q <= STri;
          end else if (kept_q == exp_q) begin
            st_q <= StTriangle; state_q <= SEmit; rd_q <= '0;
          end else begin
            st_q <= StMismatch; state_q <= SErr; outv_q <= 1'b1;
          end
        end
        SApp: begin
          if (bcnt_q < BaseW'(BaseDepth)) bcnt_q <= bcnt_q + 1'b1;
          add_q <= add_rest;
          if (add_rest == '0) begin
            if (has_next) begin
              i_q <= ni; j_q <= nj; k_q <= nk; state_q <= STri;
            end else if (kept_q == exp_q) begin
              st_q <= StTriangle; state_q <= SEmit; rd_q <= '0;
            end else begin
              st_q <= StMismatch; state_q <= SErr; outv_q <= 1'b1;
            end
          end
        end
        SEmit: begin
          // Fetch the entry first, then hold it until popped.
          if (!outv_q) begin
            outv_q <= 1'b1;
          end else if (pop_i) begin
            outv_q <= 1'b0;
            if (rd_q + 1'b1 == kept_q) begin
              state_q <= SLoad; n_q <= '0; ovf_q <= 1'b0;
            end else begin
              rd_q <= rd_q + 1'b1;
            end
          end
        end
        SErr: begin
          if (pop_i) begin
            outv_q <= 1'b0; state_q <= SLoad; n_q <= '0; ovf_q <= 1'b0;
          end
        end
        default: state_q <= SLoad;
      endcase
    end
  end
endmodule
